>>> sv/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Types, codes and helpers shared by the BMP pixel array decoder modules.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam logic [1:0] BPP_1  = 2'd0;
    localparam logic [1:0] BPP_4  = 2'd1;
    localparam logic [1:0] BPP_8  = 2'd2;
    localparam logic [1:0] BPP_24 = 2'd3;

    localparam logic [1:0] CFG_BPP     = 2'd0;
    localparam logic [1:0] CFG_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_PALETTE = 2'd3;

    localparam logic [1:0] KIND_PAL = 2'd0;
    localparam logic [1:0] KIND_RGB = 2'd1;
    localparam logic [1:0] KIND_IDX = 2'd2;

    localparam int QDEPTH = 4;
    localparam int CFG_DW = 13;

    typedef struct packed {
        logic [1:0]  bpp;
        logic [12:0] width;
        logic [12:0] height;
        logic [8:0]  pal_entries;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [23:0] data;
    } t_qword;

    function automatic logic [31:0] f_clamp(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v == 32'd0) r = 32'd1;
        if (v > hi)     r = hi;
        return r;
    endfunction

endpackage

>>> sv/bpd_front.sv
// ----------------------------------------------------------------------------
// bpd_front
// Takes input bytes, loads palette entries, skips row padding, joins 24 bpp
// pixels and queues one word per palette entry, pixel or index byte.
// ----------------------------------------------------------------------------
module bpd_front
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_restart,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_qword     o_word
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW1 = $clog2(MAX_HEIGHT + 1);
    localparam int HW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RBW = WW + 2;

    logic [WW-1:0]  eff_w;
    logic [HW1-1:0] eff_h;
    logic [RBW-1:0] row_bytes;
    logic [RBW-1:0] neg_rb;
    logic [1:0]     pad_amt;
    logic [8:0]     pal_need;
    logic           accept;
    logic           row_last;

    logic [8:0]     r_pal_cnt, n_pal_cnt;
    logic [1:0]     r_phase, n_phase;
    logic [7:0]     r_held_b, n_held_b;
    logic [7:0]     r_held_g, n_held_g;
    logic [RBW-1:0] r_bcnt, n_bcnt;
    logic [HW-1:0]  r_rows, n_rows;
    logic [1:0]     r_pad, n_pad;
    logic           r_done, n_done;

    assign eff_w = WW'(f_clamp(32'(i_cfg.width), 32'(MAX_WIDTH)));
    assign eff_h = HW1'(f_clamp(32'(i_cfg.height), 32'(MAX_HEIGHT)));

    always_comb begin
        case (i_cfg.bpp)
            BPP_1:   row_bytes = (RBW'(eff_w) + RBW'(7)) >> 3;
            BPP_4:   row_bytes = (RBW'(eff_w) + RBW'(1)) >> 1;
            BPP_8:   row_bytes = RBW'(eff_w);
            default: row_bytes = RBW'(eff_w) + (RBW'(eff_w) << 1);
        endcase
    end

    assign neg_rb  = RBW'(0) - row_bytes;
    assign pad_amt = neg_rb[1:0];

    always_comb begin
        pal_need = 9'd0;
        if (i_cfg.bpp != BPP_24) begin
            if (i_cfg.pal_entries != 9'd0) begin
                pal_need = i_cfg.pal_entries;
            end else begin
                case (i_cfg.bpp)
                    BPP_1:   pal_need = 9'd2;
                    BPP_4:   pal_need = 9'd16;
                    default: pal_need = 9'd256;
                endcase
            end
            if (pal_need > 9'(PALETTE_DEPTH)) pal_need = 9'(PALETTE_DEPTH);
        end
    end

    assign o_ready  = !i_q_full && !i_restart;
    assign accept   = i_valid && o_ready;
    assign row_last = (r_bcnt == row_bytes - RBW'(1));

    always_comb begin
        n_pal_cnt = r_pal_cnt;
        n_phase   = r_phase;
        n_held_b  = r_held_b;
        n_held_g  = r_held_g;
        n_bcnt    = r_bcnt;
        n_rows    = r_rows;
        n_pad     = r_pad;
        n_done    = r_done;
        o_push    = 1'b0;
        o_word    = '{kind: KIND_IDX, addr: r_pal_cnt[7:0], data: {16'd0, i_data_byte}};
        if (accept && !r_done) begin
            if (r_pal_cnt < pal_need) begin
                case (r_phase)
                    2'd0: n_held_b = i_data_byte;
                    2'd1: n_held_g = i_data_byte;
                    2'd2: begin
                        o_push      = 1'b1;
                        o_word.kind = KIND_PAL;
                        o_word.data = {i_data_byte, r_held_g, r_held_b};
                    end
                    default: n_pal_cnt = r_pal_cnt + 9'd1;
                endcase
                n_phase = r_phase + 2'd1;
            end else if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else begin
                if (i_cfg.bpp == BPP_24) begin
                    case (r_phase)
                        2'd0: begin
                            n_held_b = i_data_byte;
                            n_phase  = 2'd1;
                        end
                        2'd1: begin
                            n_held_g = i_data_byte;
                            n_phase  = 2'd2;
                        end
                        default: begin
                            o_push      = 1'b1;
                            o_word.kind = KIND_RGB;
                            o_word.data = {i_data_byte, r_held_g, r_held_b};
                            n_phase     = 2'd0;
                        end
                    endcase
                end else begin
                    o_push = 1'b1;
                end
                if (row_last) begin
                    n_bcnt = '0;
                    if (r_rows == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_rows = r_rows - HW'(1);
                        n_pad  = pad_amt;
                    end
                end else begin
                    n_bcnt = r_bcnt + RBW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_cnt <= '0;
            r_phase   <= '0;
            r_held_b  <= '0;
            r_held_g  <= '0;
            r_bcnt    <= '0;
            r_rows    <= '0;
            r_pad     <= '0;
            r_done    <= 1'b0;
        end else if (i_restart) begin
            r_pal_cnt <= '0;
            r_phase   <= '0;
            r_held_b  <= '0;
            r_held_g  <= '0;
            r_bcnt    <= '0;
            r_rows    <= HW'(eff_h - HW1'(1));
            r_pad     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_pal_cnt <= n_pal_cnt;
            r_phase   <= n_phase;
            r_held_b  <= n_held_b;
            r_held_g  <= n_held_g;
            r_bcnt    <= n_bcnt;
            r_rows    <= n_rows;
            r_pad     <= n_pad;
            r_done    <= n_done;
        end
    end

endmodule

>>> sv/bpd_queue.sv
// ----------------------------------------------------------------------------
// bpd_queue
// Short first-in first-out queue of words between the front and back parts.
// ----------------------------------------------------------------------------
module bpd_queue
    import bpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_flush,
    input  logic   i_push,
    input  t_qword i_word,
    output logic   o_full,
    output logic   o_valid,
    output t_qword o_word,
    input  logic   i_pop
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_qword        r_mem [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PW'(1);
            if (do_pop)  r_rp <= r_rp + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/bpd_back.sv
// ----------------------------------------------------------------------------
// bpd_back
// Writes palette entries, unpacks index bytes one pixel a cycle if unstalled,
// looks each index up in the palette and tracks row and column of every pixel.
// ----------------------------------------------------------------------------
module bpd_back
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_qword      i_q_word,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [11:0] o_pixel_row,
    output logic [11:0] o_pixel_column,
    output logic        o_last_of_byte,
    output logic        o_last_of_image
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int HW1 = $clog2(MAX_HEIGHT + 1);
    localparam int HW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [23:0]    r_pal [PALETTE_DEPTH];
    logic [23:0]    r_rd;

    logic [WW-1:0]  eff_w;
    logic [HW1-1:0] eff_h;
    logic [7:0]     idx;
    logic           is_pal;
    logic           is_rgb;
    logic           byte_end;
    logic           row_end;
    logic           fire;
    logic           pal_we;
    logic           out_adv;
    logic           s2_ready;
    logic [23:0]    s2_colour;

    logic [2:0]     r_k;
    logic [CW-1:0]  r_col;
    logic [HW-1:0]  r_rows;

    logic           r_s2_valid;
    logic           r_s2_lut;
    logic           r_s2_oob;
    logic [23:0]    r_s2_rgb;
    logic [11:0]    r_s2_row;
    logic [11:0]    r_s2_col;
    logic           r_s2_lob;
    logic           r_s2_loi;

    logic           r_o_valid;
    logic [23:0]    r_o_rgb;
    logic [11:0]    r_o_row;
    logic [11:0]    r_o_col;
    logic           r_o_lob;
    logic           r_o_loi;

    assign eff_w = WW'(f_clamp(32'(i_cfg.width), 32'(MAX_WIDTH)));
    assign eff_h = HW1'(f_clamp(32'(i_cfg.height), 32'(MAX_HEIGHT)));

    assign is_pal = (i_q_word.kind == KIND_PAL);
    assign is_rgb = (i_q_word.kind == KIND_RGB);

    always_comb begin
        case (i_cfg.bpp)
            BPP_1: begin
                idx      = {7'd0, i_q_word.data[3'd7 - r_k]};
                byte_end = (r_k == 3'd7);
            end
            BPP_4: begin
                idx      = r_k[0] ? {4'd0, i_q_word.data[3:0]} : {4'd0, i_q_word.data[7:4]};
                byte_end = (r_k == 3'd1);
            end
            default: begin
                idx      = i_q_word.data[7:0];
                byte_end = 1'b1;
            end
        endcase
        if (is_rgb) byte_end = 1'b1;
    end

    assign row_end  = ((WW'(r_col) + WW'(1)) == eff_w);
    assign out_adv  = !r_o_valid || i_ready;
    assign s2_ready = !r_s2_valid || out_adv;
    assign pal_we   = i_q_valid && is_pal && !i_restart;
    assign fire     = i_q_valid && !is_pal && s2_ready && !i_restart;
    assign o_q_pop  = pal_we || (fire && (byte_end || row_end));

    always_ff @(posedge i_clk) begin
        if (pal_we) r_pal[i_q_word.addr[AW-1:0]] <= i_q_word.data;
        if (fire)   r_rd <= r_pal[idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s2_lut <= !is_rgb;
            r_s2_oob <= ({1'b0, idx} >= 9'(PALETTE_DEPTH));
            r_s2_rgb <= i_q_word.data;
            r_s2_row <= 12'(r_rows);
            r_s2_col <= 12'(r_col);
            r_s2_lob <= byte_end || row_end;
            r_s2_loi <= row_end && (r_rows == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= '0;
            r_col      <= '0;
            r_rows     <= '0;
            r_s2_valid <= 1'b0;
        end else if (i_restart) begin
            r_k        <= '0;
            r_col      <= '0;
            r_rows     <= HW'(eff_h - HW1'(1));
            r_s2_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_k <= (byte_end || row_end) ? 3'd0 : r_k + 3'd1;
                if (row_end) begin
                    r_col <= '0;
                    if (r_rows != '0) r_rows <= r_rows - HW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (s2_ready) r_s2_valid <= fire;
        end
    end

    assign s2_colour = r_s2_lut ? (r_s2_oob ? 24'd0 : r_rd) : r_s2_rgb;

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s2_valid) begin
            r_o_rgb <= s2_colour;
            r_o_row <= r_s2_row;
            r_o_col <= r_s2_col;
            r_o_lob <= r_s2_lob;
            r_o_loi <= r_s2_loi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_s2_valid;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_red           = r_o_rgb[23:16];
    assign o_green         = r_o_rgb[15:8];
    assign o_blue          = r_o_rgb[7:0];
    assign o_pixel_row     = r_o_row;
    assign o_pixel_column  = r_o_col;
    assign o_last_of_byte  = r_o_lob;
    assign o_last_of_image = r_o_loi;

endmodule

>>> sv/bmp_pixel_array_decoder_core.sv
// Path: a taken byte goes through the queue, stage-2 and output registers to o_valid.
// Throughput: one pixel per cycle through the single palette read port unless stalled;
// a 1 bpp byte holds 8 indices, a 4 bpp byte 2, an 8 bpp byte 1, a 24 bpp pixel 3 bytes.
// Palette, padding and partial 24 bpp bytes go in one per cycle unless the queue is full.
// Reset: synchronous, active low; decode restarts in the cycle after reset or any
// register write, and the palette contents are kept.
// ----------------------------------------------------------------------------
// bmp_pixel_array_decoder_core
// Decodes the BMP pixel array byte stream into pixels with row and column.
// ----------------------------------------------------------------------------
module bmp_pixel_array_decoder_core
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [11:0]       o_pixel_row,
    output logic [11:0]       o_pixel_column,
    output logic              o_last_of_byte,
    output logic              o_last_of_image
);

    t_cfg   r_cfg;
    logic   r_restart;
    logic   q_push;
    t_qword q_in;
    logic   q_full;
    logic   q_valid;
    t_qword q_out;
    logic   q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '{bpp: BPP_24, width: 13'd1, height: 13'd1, pal_entries: 9'd0};
            r_restart <= 1'b1;
        end else begin
            r_restart <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BPP:     r_cfg.bpp         <= i_cfg_data[1:0];
                    CFG_WIDTH:   r_cfg.width       <= i_cfg_data[12:0];
                    CFG_HEIGHT:  r_cfg.height      <= i_cfg_data[12:0];
                    CFG_PALETTE: r_cfg.pal_entries <= i_cfg_data[8:0];
                    default:     r_cfg             <= r_cfg;
                endcase
            end
        end
    end

    bpd_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (r_restart),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_word      (q_in)
    );

    bpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (r_restart),
        .i_push  (q_push),
        .i_word  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_word  (q_out),
        .i_pop   (q_pop)
    );

    bpd_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_restart       (r_restart),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_word        (q_out),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_pixel_row     (o_pixel_row),
        .o_pixel_column  (o_pixel_column),
        .o_last_of_byte  (o_last_of_byte),
        .o_last_of_image (o_last_of_image)
    );

endmodule

>>> sv/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks on the decoder's pixel output, bound to the top level.
// ----------------------------------------------------------------------------
module bpd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_pixel_row,
    input  logic [11:0] i_pixel_column,
    input  logic        i_last_of_byte,
    input  logic        i_last_of_image
);

    logic r_img_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_img_done <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_last_of_image) begin
            r_img_done <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red) && $stable(i_green)
            && $stable(i_blue) && $stable(i_pixel_row) && $stable(i_pixel_column))
        else $error("stalled pixel word changed");

    a_quiet_after_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_img_done |-> !i_out_valid)
        else $error("pixel after last pixel of image");

    a_last_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_of_image |-> i_last_of_byte && (i_pixel_row == 12'd0))
        else $error("last pixel of image not on top row or not last of byte");

    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output valid straight after reset");

endmodule

bind bmp_pixel_array_decoder_core bpd_checker u_bpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .i_out_valid     (o_valid),
    .i_out_ready     (i_ready),
    .i_red           (o_red),
    .i_green         (o_green),
    .i_blue          (o_blue),
    .i_pixel_row     (o_pixel_row),
    .i_pixel_column  (o_pixel_column),
    .i_last_of_byte  (o_last_of_byte),
    .i_last_of_image (o_last_of_image)
);

>>> sim/bpd_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pixel_checker
// Follows the register writes and the accepted bytes of the BMP pixel array
// decoder, works out each pixel it must emit, and compares every accepted
// pixel word in order against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module bpd_pixel_checker
    import bpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_byte_valid,
    input  logic              i_byte_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_pixel_valid,
    input  logic              i_pixel_ready,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [11:0]       i_pixel_row,
    input  logic [11:0]       i_pixel_column,
    input  logic              i_last_of_byte,
    input  logic              i_last_of_image,
    output int                o_fail_count,
    output int                o_waiting
);

    localparam int MAX_DIM     = 4096;
    localparam int COLOURS     = 256;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] column;
        logic        last_byte;
        logic        last_image;
    } pixel_t;

    pixel_t      expected_pixels[$];
    logic [23:0] colour_map [COLOURS];

    logic [1:0]  fmt_bpp;
    logic [12:0] fmt_width;
    logic [12:0] fmt_height;
    logic [8:0]  fmt_entries;

    logic [8:0]  entries_loaded;
    logic [1:0]  byte_phase;
    logic [12:0] column_at;
    logic [12:0] rows_to_go;
    logic [1:0]  pad_to_skip;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;
    logic        image_complete;

    int fail_total     = 0;
    int pixels_pending = 0;

    assign o_fail_count = fail_total;
    assign o_waiting    = pixels_pending;

    function automatic logic [12:0] clamped(input logic [12:0] v);
        if (v == 13'd0) return 13'd1;
        if (v > 13'(MAX_DIM)) return 13'(MAX_DIM);
        return v;
    endfunction

    function automatic int bits_per_index();
        case (fmt_bpp)
            BPP_1:   return 1;
            BPP_4:   return 4;
            BPP_8:   return 8;
            default: return 24;
        endcase
    endfunction

    function automatic logic [8:0] entries_needed();
        int n;
        if (fmt_bpp == BPP_24) return 9'd0;
        n = (fmt_entries != 9'd0) ? int'(fmt_entries) : (1 << bits_per_index());
        if (n > COLOURS) n = COLOURS;
        return 9'(n);
    endfunction

    function automatic logic [1:0] row_padding();
        int row_bytes;
        row_bytes = (int'(clamped(fmt_width)) * bits_per_index() + 7) / 8;
        return 2'((4 - (row_bytes % 4)) % 4);
    endfunction

    function automatic void restart_decode();
        entries_loaded = '0;
        byte_phase     = '0;
        column_at      = '0;
        rows_to_go     = clamped(fmt_height) - 13'd1;
        pad_to_skip    = '0;
        held_blue      = '0;
        held_green     = '0;
        image_complete = 1'b0;
    endfunction

    // place one pixel and advance; true when its row has just closed
    function automatic bit place_pixel(input logic [23:0] rgb, output pixel_t px);
        logic [12:0] w;
        w             = clamped(fmt_width);
        px.red        = rgb[23:16];
        px.green      = rgb[15:8];
        px.blue       = rgb[7:0];
        px.row        = rows_to_go[11:0];
        px.column     = column_at[11:0];
        px.last_byte  = 1'b0;
        px.last_image = (column_at + 13'd1 >= w) && (rows_to_go == 13'd0);
        column_at     = column_at + 13'd1;
        if (column_at < w) return 1'b0;
        column_at = '0;
        if (rows_to_go == 13'd0) begin
            image_complete = 1'b1;
        end else begin
            rows_to_go  = rows_to_go - 13'd1;
            pad_to_skip = row_padding();
        end
        return 1'b1;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        pixel_t     px [8];
        int         n;
        int         bits;
        logic [7:0] idx;
        n = 0;
        if (image_complete) return;
        if (entries_loaded < entries_needed()) begin
            case (byte_phase)
                2'd0:    held_blue = b;
                2'd1:    held_green = b;
                2'd2:    colour_map[entries_loaded[7:0]] = {b, held_green, held_blue};
                default: entries_loaded = entries_loaded + 9'd1;
            endcase
            byte_phase = byte_phase + 2'd1;
            return;
        end
        if (pad_to_skip != 2'd0) begin
            pad_to_skip = pad_to_skip - 2'd1;
            return;
        end
        if (fmt_bpp == BPP_24) begin
            case (byte_phase)
                2'd0: begin
                    held_blue  = b;
                    byte_phase = 2'd1;
                end
                2'd1: begin
                    held_green = b;
                    byte_phase = 2'd2;
                end
                default: begin
                    byte_phase = 2'd0;
                    void'(place_pixel({b, held_green, held_blue}, px[0]));
                    n = 1;
                end
            endcase
        end else begin
            bits = bits_per_index();
            for (int k = 0; k < 8 / bits; k++) begin
                idx = 8'((b >> (8 - bits * (k + 1))) & ((1 << bits) - 1));
                n++;
                if (place_pixel(colour_map[idx], px[n - 1])) break;
            end
        end
        if (n > 0) px[n - 1].last_byte = 1'b1;
        for (int i = 0; i < n; i++) expected_pixels.push_back(px[i]);
    endtask

    function automatic string pixel_text(input pixel_t px);
        return $sformatf("rgb=%02h%02h%02h row=%0d col=%0d last_byte=%0b last_image=%0b",
                         px.red, px.green, px.blue, px.row, px.column,
                         px.last_byte, px.last_image);
    endfunction

    task automatic check_pixel();
        pixel_t got;
        pixel_t want;
        got = '{i_red, i_green, i_blue, i_pixel_row, i_pixel_column,
                i_last_of_byte, i_last_of_image};
        if (expected_pixels.size() == 0) begin
            fail_total++;
            $display("%0t: unexpected pixel word: expected none, got %s",
                     $time, pixel_text(got));
            return;
        end
        want = expected_pixels.pop_front();
        if (got !== want) begin
            fail_total++;
            $display("%0t: pixel mismatch: expected %s, got %s",
                     $time, pixel_text(want), pixel_text(got));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_bpp     = BPP_24;
            fmt_width   = 13'd1;
            fmt_height  = 13'd1;
            fmt_entries = 9'd0;
            restart_decode();
            expected_pixels.delete();
        end else begin
            if (i_pixel_valid && i_pixel_ready) check_pixel();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BPP:    fmt_bpp = i_cfg_data[1:0];
                    CFG_WIDTH:  fmt_width = i_cfg_data[12:0];
                    CFG_HEIGHT: fmt_height = i_cfg_data[12:0];
                    default:    fmt_entries = i_cfg_data[8:0];
                endcase
                restart_decode();
            end
            if (i_byte_valid && i_byte_ready) decode_byte(i_data_byte);
        end
        pixels_pending = expected_pixels.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the BMP pixel array decoder with palette and pixel byte streams over
// a range of depths, sizes and palette counts, with random gaps on both
// channels; the checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb;
    import bpd_pkg::*;

    localparam int RANDOM_WORDS  = 240;
    localparam int SETTLE_CYCLES = 10;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [1:0]        cfg_index   = CFG_BPP;
    logic [CFG_DW-1:0] cfg_data    = '0;
    logic              byte_valid  = 1'b0;
    logic              byte_ready;
    logic [7:0]        data_byte   = '0;
    logic              pixel_valid;
    logic              pixel_ready = 1'b0;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [11:0]       pixel_row;
    logic [11:0]       pixel_column;
    logic              last_of_byte;
    logic              last_of_image;
    int                fail_count;
    int                pixels_waiting;

    int send_gap_pct    = 21;
    int recv_gap_pct    = 54;
    int palette_written = 0;
    int random_words    = 0;

    bmp_pixel_array_decoder_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (byte_valid),
        .o_ready        (byte_ready),
        .i_data_byte    (data_byte),
        .o_valid        (pixel_valid),
        .i_ready        (pixel_ready),
        .o_red          (red),
        .o_green        (green),
        .o_blue         (blue),
        .o_pixel_row    (pixel_row),
        .o_pixel_column (pixel_column),
        .o_last_of_byte (last_of_byte),
        .o_last_of_image(last_of_image)
    );

    bpd_pixel_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_byte_valid   (byte_valid),
        .i_byte_ready   (byte_ready),
        .i_data_byte    (data_byte),
        .i_pixel_valid  (pixel_valid),
        .i_pixel_ready  (pixel_ready),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .i_pixel_row    (pixel_row),
        .i_pixel_column (pixel_column),
        .i_last_of_byte (last_of_byte),
        .i_last_of_image(last_of_image),
        .o_fail_count   (fail_count),
        .o_waiting      (pixels_waiting)
    );

    always #1 clk = ~clk;

    always @(negedge clk) begin
        pixel_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int depth_of(input logic [1:0] bpp);
        case (bpp)
            BPP_1:   return 1;
            BPP_4:   return 4;
            BPP_8:   return 8;
            default: return 24;
        endcase
    endfunction

    function automatic int clamp_dim(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (v > 13'd4096) return 4096;
        return int'(v);
    endfunction

    function automatic int entries_to_load(input logic [1:0] bpp, input logic [8:0] pal);
        int n;
        if (bpp == BPP_24) return 0;
        n = (pal != 9'd0) ? int'(pal) : (1 << depth_of(bpp));
        return (n > 256) ? 256 : n;
    endfunction

    function automatic int array_bytes(input logic [1:0] bpp, input logic [12:0] w,
                                       input logic [12:0] h);
        int row_bytes;
        int pad;
        row_bytes = (clamp_dim(w) * depth_of(bpp) + 7) / 8;
        pad       = (4 - (row_bytes % 4)) % 4;
        return clamp_dim(h) * (row_bytes + pad) - pad;
    endfunction

    // indices only ever select palette entries already loaded
    function automatic logic [7:0] pixel_byte(input logic [1:0] bpp);
        int         bits;
        logic [7:0] b;
        bits = depth_of(bpp);
        if (bits == 24 || palette_written >= (1 << bits)) return 8'($urandom);
        b = '0;
        for (int k = 0; k < 8 / bits; k++) begin
            b = (b << bits) | 8'($urandom_range(0, palette_written - 1));
        end
        return b;
    endfunction

    task automatic feed_byte(input logic [7:0] value);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= value;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_pixels();
        byte_valid <= 1'b0;
        while (pixels_waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_format(input logic [1:0] bpp, input logic [12:0] w,
                              input logic [12:0] h, input logic [8:0] pal);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BPP;
        cfg_data  <= {11'($urandom), bpp};
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= CFG_PALETTE;
        cfg_data  <= {4'($urandom), pal};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_image(input logic [1:0] bpp, input logic [12:0] w, input logic [12:0] h,
                             input logic [8:0] pal, input int pal_words, input int pix_words,
                             input int tail_words);
        drain_pixels();
        set_format(bpp, w, h, pal);
        repeat (pal_words) feed_byte(8'($urandom));
        if ((pal_words + 1) / 4 > palette_written) palette_written = (pal_words + 1) / 4;
        repeat (pix_words) feed_byte(pixel_byte(bpp));
        repeat (tail_words) feed_byte(8'($urandom));
    endtask

    initial begin
        logic [1:0]  bpp;
        logic [12:0] w;
        logic [12:0] h;
        logic [8:0]  pal;
        int          need;
        int          whole;
        int          pick;
        int          pal_words;
        int          pix_words;
        int          tail_words;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset format is a single 24 bpp pixel; the trailing words are dropped
        feed_byte(8'h00);
        feed_byte(8'hFF);
        feed_byte(8'h80);
        feed_byte(8'hFF);
        feed_byte(8'h00);

        run_image(BPP_1, 13'd0, 13'd3, 9'd0, 8, array_bytes(BPP_1, 13'd0, 13'd3), 1);
        run_image(BPP_8, 13'd5, 13'd2, 9'd6, 24, array_bytes(BPP_8, 13'd5, 13'd2), 2);
        run_image(BPP_1, 13'd8191, 13'd8191, 9'd2, 8, 40, 0);

        while (random_words < RANDOM_WORDS) begin
            pick = random_words * 3 / RANDOM_WORDS;
            send_gap_pct = (pick == 0) ? 21 : (pick == 1) ? 54 : 0;
            recv_gap_pct = (pick == 0) ? 54 : (pick == 1) ? 21 : 0;

            bpp  = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            w    = (pick == 0) ? 13'd0 :
                   (pick == 1) ? 13'($urandom_range(4096, 8191)) : 13'($urandom_range(1, 12));
            pick = $urandom_range(0, 9);
            h    = (pick == 0) ? 13'd0 :
                   (pick == 1) ? 13'($urandom_range(4096, 8191)) : 13'($urandom_range(1, 4));
            if (bpp == BPP_24) begin
                pal = 9'($urandom);
            end else if (bpp != BPP_8 && $urandom_range(0, 2) == 0) begin
                pal = 9'd0;
            end else begin
                pal = 9'($urandom_range(1, 24));
            end

            need       = entries_to_load(bpp, pal);
            whole      = array_bytes(bpp, w, h);
            pick       = $urandom_range(0, 9);
            tail_words = 0;
            if (pick == 0 && need > 0) begin
                pal_words = $urandom_range(0, need * 4 - 1);
                pix_words = 0;
            end else begin
                pal_words = need * 4;
                if (pick < 7 && whole <= 120) begin
                    pix_words  = whole;
                    tail_words = $urandom_range(0, 3);
                end else begin
                    pix_words = $urandom_range(1, (whole < 40) ? whole : 40);
                end
            end
            run_image(bpp, w, h, pal, pal_words, pix_words, tail_words);
            random_words += pal_words + pix_words;
        end

        drain_pixels();
        if (fail_count == 0 && pixels_waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
